// File: design/gfcv_pkg.sv
// ----------------------------------------------------------------------------
// gfcv_pkg: shared types and constants for the Green's function cell value
// Register map codes, stage counts and datapath widths used by all modules.
// ----------------------------------------------------------------------------
package gfcv_pkg;

   // register map, one 32-bit word each
   typedef enum logic [2:0] {
      REG_RANK,
      REG_LEFT_X,
      REG_LEFT_Y,
      REG_LEFT_Z,
      REG_CELL_WIDTH,
      REG_GRAV
   } reg_index_type;

   localparam logic [1:0] RANK_NONE   = 2'd0;
   localparam logic [1:0] RANK_LINEAR = 2'd1;
   localparam logic [1:0] RANK_LOG    = 2'd2;
   localparam logic [1:0] RANK_RECIP  = 2'd3;

   // round(2^32/(4*pi)) and 2^32*ln2/(2*pi)
   localparam logic [28:0] INV4PI  = 29'd341782638;
   localparam logic [28:0] LN2_2PI = 29'd473811343;

   localparam int IDX_W   = 10;
   localparam int CW_W    = 31;
   localparam int R_W     = 75;  // r = max(d, cw) * cw, Q32
   localparam int GN_W    = 60;  // grav times a 29-bit constant
   localparam int Q1_W    = 73;
   localparam int Q2_W    = 34;
   localparam int Q3_W    = 61;
   localparam int OUT_W   = 48;

   localparam int DIST_LAT = 51;  // accept stage up to the r register
   localparam int DIV_LAT  = 61;
   localparam int LOG_LAT  = 26;
   localparam int LIN_LAT  = 2;

   typedef struct packed {
      logic [1:0]        rank;
      logic [31:0]       left_x;
      logic [31:0]       left_y;
      logic [31:0]       left_z;
      logic [CW_W-1:0]   cell_w;   // never zero
      logic [CW_W-1:0]   grav;
      logic [GN_W-1:0]   g_inv;    // grav * INV4PI
      logic [GN_W-1:0]   g_ln;     // grav * LN2_2PI
   } cfg_type;

endpackage

// File: design/gfcv_dist.sv
// ----------------------------------------------------------------------------
// gfcv_dist: cell distance pipeline
// Positions, squared distance, bit-per-stage square root, then
// r = max(d, cell_width) * cell_width.
// ----------------------------------------------------------------------------
module gfcv_dist
   import gfcv_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [IDX_W-1:0] idx_x,
   input  logic [IDX_W-1:0] idx_y,
   input  logic [IDX_W-1:0] idx_z,
   input  cfg_type          cfg,
   output logic [R_W-1:0]   r
);
   localparam int SQ_BITS = 44;

   logic [IDX_W-1:0] idx [3];
   logic [31:0]      left [3];
   logic [40:0]      prod_ff [3];
   logic [41:0]      mag_ff [3], mag_in [3];
   logic [41:0]      hh_ff [3], hl_ff [3], ll_ff [3];
   logic [83:0]      sq_ff [3];
   logic [85:0]      sum_ff;
   logic [87:0]      rem_ff [SQ_BITS];
   logic [43:0]      root_ff [SQ_BITS];
   logic [43:0]      dmax;
   logic [52:0]      plo_ff, phi_ff;
   logic [R_W-1:0]   r_ff;

   assign idx[0]  = idx_x;
   assign idx[1]  = idx_y;
   assign idx[2]  = idx_z;
   assign left[0] = cfg.left_x;
   assign left[1] = cfg.left_y;
   assign left[2] = cfg.left_z;

   always_comb begin
      logic [42:0] pos;
      for (int k = 0; k < 3; k++) begin
         pos = {{11{left[k][31]}}, left[k]} + {2'b00, prod_ff[k]};
         mag_in[k] = pos[42] ? 42'(~pos + 43'd1) : pos[41:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= 41'(idx[k]) * 41'(cfg.cell_w);
            mag_ff[k]  <= mag_in[k];
            hh_ff[k]   <= 42'(mag_ff[k][41:21]) * 42'(mag_ff[k][41:21]);
            hl_ff[k]   <= 42'(mag_ff[k][41:21]) * 42'(mag_ff[k][20:0]);
            ll_ff[k]   <= 42'(mag_ff[k][20:0]) * 42'(mag_ff[k][20:0]);
            sq_ff[k]   <= ({42'd0, hh_ff[k]} << 42) + ({42'd0, hl_ff[k]} << 22)
                          + {42'd0, ll_ff[k]};
         end
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      end
   end

   // restoring square root, one result bit per stage, MSB first
   for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
      localparam int B = SQ_BITS - 1 - j;
      logic [87:0] rem_prev, trial, rem_in;
      logic [43:0] root_prev, root_in;
      if (j == 0) begin : g_first
         assign rem_prev  = {2'b00, sum_ff};
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end
      assign trial = ({44'd0, root_prev} << (B + 1)) | (88'd1 << (2 * B));
      always_comb begin
         if (trial <= rem_prev) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (44'd1 << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   // raise to at least one cell
   assign dmax = (root_ff[SQ_BITS-1] < {13'd0, cfg.cell_w}) ?
                 {13'd0, cfg.cell_w} : root_ff[SQ_BITS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= 53'(dmax[21:0]) * 53'(cfg.cell_w);
         phi_ff <= 53'(dmax[43:22]) * 53'(cfg.cell_w);
         r_ff   <= ({22'd0, phi_ff} << 22) + {22'd0, plo_ff};
      end
   end

   assign r = r_ff;

endmodule

// File: design/gfcv_div.sv
// ----------------------------------------------------------------------------
// gfcv_div: reciprocal kernel divider
// Pipelined restoring division of grav*INV4PI by r, one quotient bit per
// stage, then round half up. Zero when r does not fit in 64 bits.
// ----------------------------------------------------------------------------
module gfcv_div
   import gfcv_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [R_W-1:0]   r,
   input  logic [GN_W-1:0]  numer,
   output logic [Q3_W-1:0]  quot
);
   localparam int QBITS = GN_W;

   logic [63:0]      rem_ff [QBITS];
   logic [QBITS-1:0] quo_ff [QBITS];
   logic [63:0]      den_ff [QBITS];
   logic             big_ff [QBITS];
   logic             round_up;
   logic [Q3_W-1:0]  quot_ff;

   for (genvar j = 0; j < QBITS; j++) begin : g_step
      logic [63:0]      rem_prev, den_prev, rem_in;
      logic [QBITS-1:0] quo_prev, quo_in;
      logic             big_prev;
      logic [64:0]      shifted;
      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign den_prev = r[63:0];
         assign big_prev = |r[R_W-1:64];
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign big_prev = big_ff[j-1];
      end
      always_comb begin
         shifted = {rem_prev, numer[QBITS-1-j]};
         if (shifted >= {1'b0, den_prev}) begin
            rem_in = 64'(shifted - {1'b0, den_prev});
            quo_in = quo_prev | (QBITS'(1) << (QBITS - 1 - j));
         end else begin
            rem_in = shifted[63:0];
            quo_in = quo_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_prev;
            big_ff[j] <= big_prev;
         end
      end
   end

   assign round_up = {rem_ff[QBITS-1], 1'b0} >= {1'b0, den_ff[QBITS-1]};

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= big_ff[QBITS-1] ? '0 :
                    {1'b0, quo_ff[QBITS-1]} + Q3_W'(round_up);
      end
   end

   assign quot = quot_ff;

endmodule

// File: design/gfcv_log.sv
// ----------------------------------------------------------------------------
// gfcv_log: logarithmic kernel
// Normalise r by a binary shift ladder, 16 squaring stages for the log2
// fraction, then scale by grav*LN2_2PI and round half up.
// ----------------------------------------------------------------------------
module gfcv_log
   import gfcv_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [R_W-1:0]   r,
   input  logic [GN_W-1:0]  scale,
   output logic [Q2_W-1:0]  mag,
   output logic             neg
);
   localparam int NSH  = 7;
   localparam int NSQ  = 16;
   localparam int LOG_OFFSET = 32 << 16;

   logic [R_W-1:0] x_ff [NSH];
   logic [6:0]     sh_ff [NSH];
   logic [31:0]    y_ff [NSQ];
   logic [NSQ-1:0] fr_ff [NSQ];
   logic [6:0]     e_ff [NSQ];
   logic [22:0]    lval;
   logic [21:0]    lmag_ff;
   logic           lneg_ff, mneg_ff, neg_ff;
   logic [51:0]    mlo_ff, mhi_ff;
   logic [81:0]    psum;
   logic [Q2_W-1:0] mag_ff;

   for (genvar j = 0; j < NSH; j++) begin : g_norm
      localparam int K = 64 >> j;
      logic [R_W-1:0] x_prev;
      logic [6:0]     sh_prev;
      if (j == 0) begin : g_first
         assign x_prev  = r;
         assign sh_prev = '0;
      end else begin : g_next
         assign x_prev  = x_ff[j-1];
         assign sh_prev = sh_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (x_prev[R_W-1 -: K] == '0) begin
               x_ff[j]  <= x_prev << K;
               sh_ff[j] <= sh_prev + 7'(K);
            end else begin
               x_ff[j]  <= x_prev;
               sh_ff[j] <= sh_prev;
            end
         end
      end
   end

   for (genvar j = 0; j < NSQ; j++) begin : g_sq
      logic [31:0]    y_prev, y_in;
      logic [NSQ-1:0] fr_prev;
      logic [6:0]     e_prev;
      logic [63:0]    prod;
      if (j == 0) begin : g_first
         assign y_prev  = x_ff[NSH-1][R_W-1 -: 32];
         assign fr_prev = '0;
         assign e_prev  = 7'(R_W - 1) - sh_ff[NSH-1];
      end else begin : g_next
         assign y_prev  = y_ff[j-1];
         assign fr_prev = fr_ff[j-1];
         assign e_prev  = e_ff[j-1];
      end
      assign prod = 64'(y_prev) * 64'(y_prev);
      // keep y in [1, 2): halve and emit a one when the square reaches 2
      assign y_in = prod[63] ? prod[63:32] : prod[62:31];
      always_ff @(posedge clock) begin
         if (en) begin
            y_ff[j]  <= y_in;
            fr_ff[j] <= {fr_prev[NSQ-2:0], prod[63]};
            e_ff[j]  <= e_prev;
         end
      end
   end

   assign lval = {e_ff[NSQ-1], fr_ff[NSQ-1]};
   assign psum = ({30'd0, mhi_ff} << 30) + {30'd0, mlo_ff} + (82'd1 << 47);

   always_ff @(posedge clock) begin
      if (en) begin
         lneg_ff <= lval > 23'(LOG_OFFSET);
         lmag_ff <= (lval > 23'(LOG_OFFSET)) ? 22'(lval - 23'(LOG_OFFSET))
                                              : 22'(23'(LOG_OFFSET) - lval);
         mlo_ff  <= 52'(scale[29:0]) * 52'(lmag_ff);
         mhi_ff  <= 52'(scale[59:30]) * 52'(lmag_ff);
         mneg_ff <= lneg_ff;
         mag_ff  <= psum[81:48];
         neg_ff  <= mneg_ff;
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

// File: design/greens_function_cell_value.sv
// ----------------------------------------------------------------------------
// greens_function_cell_value: real-space Poisson Green's function per cell
// Fixed-point pipeline: cell indices in, signed Q31.16 potential out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry a cell's x, y and z index on req_* with valid/ready.
//   Results leave on rsp_potential / rsp_saturated with valid/ready, one
//   result per request, in request order.
//   Registers (rank, left edges, cell width, G) sit on the APB port at
//   byte addresses 0, 4, ... 20; write them only while no request is in
//   flight.
//   Throughput: one request per cycle unless stalled. Results pass through
//   the 44-stage square root and the 61-stage reciprocal divider, which
//   the other two kernels are padded to match.
//   A stalled receiver freezes the whole pipeline and drops req_ready;
//   nothing is lost or repeated.
//   Reset clears all valid bits and loads rank 3, edges 0, cell width
//   and G of 1.0.
// ----------------------------------------------------------------------------
module greens_function_cell_value
   import gfcv_pkg::*;
#(
   parameter int MAX_DIM = 1024
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [IDX_W-1:0] req_index_x,
   input  logic [IDX_W-1:0] req_index_y,
   input  logic [IDX_W-1:0] req_index_z,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [OUT_W-1:0] rsp_potential,
   output logic             rsp_saturated,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int unsigned IDX_TOP = MAX_DIM - 1;
   localparam int NSTAGE  = DIST_LAT + DIV_LAT;
   localparam int LOG_PAD = DIV_LAT - LOG_LAT;
   localparam int LIN_PAD = DIV_LAT - LIN_LAT;

   logic [1:0]       rank_ff;
   logic [31:0]      left_x_ff, left_y_ff, left_z_ff;
   logic [CW_W-1:0]  cell_width_ff, grav_ff;
   logic [GN_W-1:0]  g_inv_ff, g_ln_ff;
   cfg_type          cfg;
   logic             wr;

   logic             en;
   logic [NSTAGE-1:0] v_ff;
   logic [IDX_W-1:0] idx_x, idx_y, idx_z;
   logic [R_W-1:0]   r;
   logic [Q3_W-1:0]  q3;
   logic [Q2_W-1:0]  q2;
   logic             neg2;
   logic [55:0]      lin_ff [3];
   logic [Q1_W-1:0]  q1_ff;
   logic [105:0]     lin_sum;
   logic [Q1_W-1:0]  q1_pad_ff [LIN_PAD];
   logic [Q2_W-1:0]  q2_pad_ff [LOG_PAD];
   logic             neg2_pad_ff [LOG_PAD];

   logic [Q1_W-1:0]  mag_sel, lim;
   logic             neg_sel, sat;
   logic [OUT_W-1:0] clipped, pot;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] potential_ff;
   logic             saturated_ff;

   // ---------------- register port ----------------
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff       <= RANK_RECIP;
         left_x_ff     <= '0;
         left_y_ff     <= '0;
         left_z_ff     <= '0;
         cell_width_ff <= CW_W'(65536);
         grav_ff       <= CW_W'(65536);
      end else if (wr) begin
         case (reg_index_type'(paddr[4:2]))
            REG_RANK:       rank_ff       <= pwdata[1:0];
            REG_LEFT_X:     left_x_ff     <= pwdata;
            REG_LEFT_Y:     left_y_ff     <= pwdata;
            REG_LEFT_Z:     left_z_ff     <= pwdata;
            REG_CELL_WIDTH: cell_width_ff <= pwdata[CW_W-1:0];
            REG_GRAV:       grav_ff       <= pwdata[CW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_RANK:       prdata = {30'd0, rank_ff};
         REG_LEFT_X:     prdata = left_x_ff;
         REG_LEFT_Y:     prdata = left_y_ff;
         REG_LEFT_Z:     prdata = left_z_ff;
         REG_CELL_WIDTH: prdata = {1'b0, cell_width_ff};
         REG_GRAV:       prdata = {1'b0, grav_ff};
         default:        prdata = '0;
      endcase
   end

   // scaled constants only feed stages far down the pipe
   always_ff @(posedge clock) begin
      g_inv_ff <= GN_W'(grav_ff) * GN_W'(INV4PI);
      g_ln_ff  <= GN_W'(grav_ff) * GN_W'(LN2_2PI);
   end

   always_comb begin
      cfg.rank   = rank_ff;
      cfg.left_x = left_x_ff;
      cfg.left_y = left_y_ff;
      cfg.left_z = left_z_ff;
      cfg.cell_w = (cell_width_ff == '0) ? CW_W'(1) : cell_width_ff;
      cfg.grav   = grav_ff;
      cfg.g_inv  = g_inv_ff;
      cfg.g_ln   = g_ln_ff;
   end

   // ---------------- pipeline control ----------------
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[NSTAGE-2:0], req_valid};
         rsp_valid_ff <= v_ff[NSTAGE-1];
      end
   end

   assign idx_x = (32'(req_index_x) > IDX_TOP) ? IDX_W'(IDX_TOP) : req_index_x;
   assign idx_y = (32'(req_index_y) > IDX_TOP) ? IDX_W'(IDX_TOP) : req_index_y;
   assign idx_z = (32'(req_index_z) > IDX_TOP) ? IDX_W'(IDX_TOP) : req_index_z;

   gfcv_dist u_dist (
      .clock (clock),
      .en    (en),
      .idx_x (idx_x),
      .idx_y (idx_y),
      .idx_z (idx_z),
      .cfg   (cfg),
      .r     (r)
   );

   gfcv_div u_div (
      .clock (clock),
      .en    (en),
      .r     (r),
      .numer (cfg.g_inv),
      .quot  (q3)
   );

   gfcv_log u_log (
      .clock (clock),
      .en    (en),
      .r     (r),
      .scale (cfg.g_ln),
      .mag   (q2),
      .neg   (neg2)
   );

   // linear kernel: G*r/2, three 25-bit slices of r
   assign lin_sum = {50'd0, lin_ff[0]} + ({50'd0, lin_ff[1]} << 25)
                  + ({50'd0, lin_ff[2]} << 50) + (106'd1 << 32);

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff[0] <= 56'(r[24:0]) * 56'(cfg.grav);
         lin_ff[1] <= 56'(r[49:25]) * 56'(cfg.grav);
         lin_ff[2] <= 56'(r[74:50]) * 56'(cfg.grav);
         q1_ff     <= lin_sum[105:33];
      end
   end

   // align the shorter kernels with the divider
   always_ff @(posedge clock) begin
      if (en) begin
         q1_pad_ff[0]   <= q1_ff;
         q2_pad_ff[0]   <= q2;
         neg2_pad_ff[0] <= neg2;
         for (int i = 1; i < LIN_PAD; i++) q1_pad_ff[i] <= q1_pad_ff[i-1];
         for (int i = 1; i < LOG_PAD; i++) begin
            q2_pad_ff[i]   <= q2_pad_ff[i-1];
            neg2_pad_ff[i] <= neg2_pad_ff[i-1];
         end
      end
   end

   // ---------------- select, sign and clamp ----------------
   always_comb begin
      case (rank_ff)
         RANK_LINEAR: begin
            mag_sel = q1_pad_ff[LIN_PAD-1];
            neg_sel = 1'b1;
         end
         RANK_LOG: begin
            mag_sel = Q1_W'(q2_pad_ff[LOG_PAD-1]);
            neg_sel = neg2_pad_ff[LOG_PAD-1];
         end
         RANK_RECIP: begin
            mag_sel = Q1_W'(q3);
            neg_sel = 1'b1;
         end
         default: begin
            mag_sel = '0;
            neg_sel = 1'b0;
         end
      endcase
      lim     = neg_sel ? (Q1_W'(1) << (OUT_W - 1)) : ((Q1_W'(1) << (OUT_W - 1)) - Q1_W'(1));
      sat     = mag_sel > lim;
      clipped = sat ? lim[OUT_W-1:0] : mag_sel[OUT_W-1:0];
      pot     = neg_sel ? (~clipped + OUT_W'(1)) : clipped;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         potential_ff <= pot;
         saturated_ff <= sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_potential = potential_ff;
   assign rsp_saturated = saturated_ff;

   // ---------------- assertions ----------------
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_potential == {1'b1, {(OUT_W-1){1'b0}}} ||
         rsp_potential == {1'b0, {(OUT_W-1){1'b1}}})
      else $error("saturated result not at a range limit");

   a_rank_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rank_ff == RANK_NONE |-> rsp_potential == '0 && !rsp_saturated)
      else $error("rank zero gave a non-zero result");

   a_attractive_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rank_ff == RANK_LINEAR || rank_ff == RANK_RECIP) |->
         rsp_potential[OUT_W-1] || rsp_potential == '0)
      else $error("positive potential from linear or reciprocal kernel");

endmodule
